// File: rtl/sdp_pkg.sv
package sdp_pkg;

    localparam int FRAC_BITS_DEF   = 24;
    localparam int VALUE_WIDTH_DEF = 48;
    localparam int FIELD_W         = 48;
    localparam int EXP_W           = 32;
    localparam int LOG_FRAC        = 30;
    localparam int EXP_FRAC        = 24;
    localparam int ADDR_W          = 6;
    localparam int DATA_W          = 64;

    localparam logic [2:0] REG_OWN_VOLUME     = 3'd0;
    localparam logic [2:0] REG_REST_DENSITY   = 3'd1;
    localparam logic [2:0] REG_KERNEL_AT_ZERO = 3'd2;
    localparam logic [2:0] REG_STIFFNESS      = 3'd3;
    localparam logic [2:0] REG_EXPONENT       = 3'd4;

    typedef struct packed {
        logic               first;
        logic               has;
        logic               last;
        logic [FIELD_W-1:0] nv;
        logic [FIELD_W-1:0] kw;
    } item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] own_volume;
        logic [FIELD_W-1:0] rest_density;
        logic [FIELD_W-1:0] kernel_at_zero;
        logic [FIELD_W-1:0] stiffness;
        logic [EXP_W-1:0]   exponent;
    } cfg_t;

    typedef enum logic [1:0] {
        SH_FRAC,
        SH_LOG,
        SH_EXP
    } mul_shift_t;

    typedef struct packed {
        logic        start;
        mul_shift_t  sh;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } mul_rsp_t;

    typedef logic [LOG_FRAC:0][31:0] root_tab_t;

    // c[k] = 2^(2^-k) in Q2.30, each entry the square root of the one before
    function automatic root_tab_t build_roots();
        root_tab_t   t;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bit_v;
        t[0] = 32'h8000_0000;
        for (int k = 1; k <= LOG_FRAC; k++) begin
            v     = {32'b0, t[k-1]} << LOG_FRAC;
            r     = '0;
            bit_v = 64'h4000_0000_0000_0000;
            for (int i = 0; i < 32; i++) begin
                if (v >= r + bit_v) begin
                    v = v - (r + bit_v);
                    r = (r >> 1) + bit_v;
                end else begin
                    r = r >> 1;
                end
                bit_v = bit_v >> 2;
            end
            t[k] = r[31:0];
        end
        return t;
    endfunction

endpackage

// File: rtl/sdp_front.sv
module sdp_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sdp_pkg::FIELD_W-1:0] s_neighbor_volume,
    input  logic [sdp_pkg::FIELD_W-1:0] s_kernel_weight,
    input  logic                        s_has_neighbor,
    input  logic                        s_last_neighbor,
    output logic                        push_valid,
    output sdp_pkg::item_t              push_item,
    input  logic                        push_ready
);
    import sdp_pkg::*;

    logic first_reg;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        push_item.first = first_reg;
        push_item.has   = s_has_neighbor;
        push_item.last  = s_last_neighbor;
        push_item.nv    = s_neighbor_volume;
        push_item.kw    = s_kernel_weight;
    end

    // mark the first item after reset and after each closing item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
        end else if (s_valid && push_ready) begin
            first_reg <= s_last_neighbor;
        end
    end

endmodule

// File: rtl/sdp_queue.sv
module sdp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    input  sdp_pkg::item_t push_item,
    output logic           push_ready,
    output logic           pop_valid,
    output sdp_pkg::item_t pop_item,
    input  logic           pop
);
    import sdp_pkg::*;

    item_t      mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(pop);
        end
    end

endmodule

// File: rtl/sdp_mul.sv
module sdp_mul #(
    parameter int FracBits = sdp_pkg::FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  sdp_pkg::mul_req_t req,
    output sdp_pkg::mul_rsp_t rsp
);
    import sdp_pkg::*;

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    mul_shift_t   sh_reg;
    logic [127:0] acc_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pidx_reg;
    logic [2:0]   cnt_reg;
    logic         active_reg;
    logic         done_reg;
    logic [63:0]  res_reg;

    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [1:0]   pp_pos;
    logic [127:0] pp_shifted;
    logic [6:0]   amt;
    logic [127:0] shifted;
    logic [63:0]  sat;

    assign a_half     = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half     = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
    assign pp_pos     = 2'(pidx_reg[1]) + 2'(pidx_reg[0]);
    assign pp_shifted = {64'b0, pp_reg} << {pp_pos, 5'b0};

    always_comb begin
        case (sh_reg)
            SH_FRAC: amt = 7'(FracBits);
            SH_LOG:  amt = 7'(LOG_FRAC);
            SH_EXP:  amt = 7'(EXP_FRAC);
            default: amt = 7'(FracBits);
        endcase
    end

    assign shifted = acc_reg >> amt;
    assign sat     = (|shifted[127:64]) ? {64{1'b1}} : shifted[63:0];

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

    // four 32x32 partial products, each registered before it is added
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                a_reg      <= req.a;
                b_reg      <= req.b;
                sh_reg     <= req.sh;
                acc_reg    <= '0;
                cnt_reg    <= 3'd0;
                active_reg <= 1'b1;
            end else if (active_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg < 3'd4) begin
                    pp_reg   <= a_half * b_half;
                    pidx_reg <= cnt_reg[1:0];
                end
                if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4) begin
                    acc_reg <= acc_reg + pp_shifted;
                end
                if (cnt_reg == 3'd5) begin
                    res_reg    <= sat;
                    done_reg   <= 1'b1;
                    active_reg <= 1'b0;
                end
            end
        end
    end

endmodule

// File: rtl/sdp_back.sv
module sdp_back #(
    parameter int FracBits   = sdp_pkg::FRAC_BITS_DEF,
    parameter int ValueWidth = sdp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sdp_pkg::cfg_t               cfg,
    input  logic                        q_valid,
    input  sdp_pkg::item_t              q_item,
    output logic                        q_pop,
    output sdp_pkg::mul_req_t           mul_req,
    input  sdp_pkg::mul_rsp_t           mul_rsp,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sdp_pkg::FIELD_W-1:0] m_density,
    output logic [sdp_pkg::FIELD_W-1:0] m_pressure,
    output logic [sdp_pkg::FIELD_W-1:0] m_mass,
    output logic                        m_clamped
);
    import sdp_pkg::*;

    localparam root_tab_t   ROOTS = build_roots();
    localparam logic [63:0] VMAX  = {64{1'b1}} >> (64 - ValueWidth);
    localparam logic [63:0] ONE   = 64'(1) << FracBits;

    typedef enum logic [4:0] {
        S_IDLE, S_SEED, S_SEED_W, S_NBR, S_NBR_W, S_CHK, S_DEN_W, S_CLS,
        S_NORM, S_SQ, S_SQ_W, S_LOG_END, S_Y_W, S_EXP, S_EXP_W, S_EXP_END,
        S_PRS_W, S_MASS, S_MASS_W, S_OUT
    } state_t;

    state_t             state_reg;
    item_t              item_reg;
    mul_req_t           mul_req_reg;
    logic [63:0]        sum_reg;
    logic [63:0]        den_reg;
    logic [63:0]        prs_reg;
    logic [63:0]        mass_reg;
    logic               clamped_reg;
    logic [63:0]        norm_reg;
    logic [5:0]         p_reg;
    logic [31:0]        m_reg;
    logic [29:0]        frac_reg;
    logic [4:0]         it_reg;
    logic               log_sel_reg;
    logic signed [39:0] logd_reg;
    logic [63:0]        y_reg;
    logic [31:0]        r_reg;
    logic [4:0]         j_reg;
    logic               m_valid_reg;
    logic [FIELD_W-1:0] m_density_reg;
    logic [FIELD_W-1:0] m_pressure_reg;
    logic [FIELD_W-1:0] m_mass_reg;
    logic               m_clamped_reg;

    logic [9:0]         lv_hi;
    logic signed [39:0] lv;
    logic signed [40:0] ldiff;
    logic [63:0]        l_pos;
    logic [64:0]        sum_add;
    logic [63:0]        res_min;
    logic [33:0]        n_int;
    logic [6:0]         n_sh;
    logic [63:0]        pw;
    logic [63:0]        pw_m1;

    assign q_pop      = (state_reg == S_IDLE) && q_valid;
    assign mul_req    = mul_req_reg;
    assign m_valid    = m_valid_reg;
    assign m_density  = m_density_reg;
    assign m_pressure = m_pressure_reg;
    assign m_mass     = m_mass_reg;
    assign m_clamped  = m_clamped_reg;

    assign lv_hi   = 10'(p_reg) - 10'(FracBits);
    assign lv      = $signed({lv_hi, frac_reg});
    assign ldiff   = $signed({logd_reg[39], logd_reg}) - $signed({lv[39], lv});
    assign l_pos   = ldiff[40] ? 64'd0 : {23'b0, ldiff};
    assign sum_add = {1'b0, sum_reg} + {1'b0, mul_rsp.res};
    assign res_min = (mul_rsp.res > VMAX) ? VMAX : mul_rsp.res;
    assign n_int   = y_reg[63:30];
    assign n_sh    = n_int[6:0] + 7'(FracBits);

    always_comb begin
        if (n_int > 34'(63 - FracBits)) begin
            pw = {64{1'b1}};
        end else if (n_sh >= 7'(LOG_FRAC)) begin
            pw = {32'b0, r_reg} << (n_sh - 7'(LOG_FRAC));
        end else begin
            pw = {32'b0, r_reg} >> (7'(LOG_FRAC) - n_sh);
        end
        pw_m1 = (pw >= ONE) ? pw - ONE : 64'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            mul_req_reg.start <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            // a start pulse lasts one cycle, spent in a wait state
            if (mul_req_reg.start) begin
                mul_req_reg.start <= 1'b0;
            end
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        item_reg  <= q_item;
                        state_reg <= S_SEED;
                    end
                end
                S_SEED: begin
                    if (item_reg.first) begin
                        mul_req_reg <= '{1'b1, SH_FRAC, {16'b0, cfg.own_volume},
                                         {16'b0, cfg.kernel_at_zero}};
                        state_reg   <= S_SEED_W;
                    end else begin
                        state_reg <= S_NBR;
                    end
                end
                S_SEED_W: begin
                    if (mul_rsp.done) begin
                        sum_reg   <= mul_rsp.res;
                        state_reg <= S_NBR;
                    end
                end
                S_NBR: begin
                    if (item_reg.has) begin
                        mul_req_reg <= '{1'b1, SH_FRAC, {16'b0, item_reg.nv},
                                         {16'b0, item_reg.kw}};
                        state_reg   <= S_NBR_W;
                    end else begin
                        state_reg <= S_CHK;
                    end
                end
                S_NBR_W: begin
                    if (mul_rsp.done) begin
                        sum_reg   <= sum_add[64] ? {64{1'b1}} : sum_add[63:0];
                        state_reg <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (item_reg.last) begin
                        mul_req_reg <= '{1'b1, SH_FRAC, sum_reg, {16'b0, cfg.rest_density}};
                        state_reg   <= S_DEN_W;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_DEN_W: begin
                    if (mul_rsp.done) begin
                        den_reg   <= res_min;
                        state_reg <= S_CLS;
                    end
                end
                S_CLS: begin
                    prs_reg     <= '0;
                    clamped_reg <= 1'b0;
                    if (cfg.rest_density == '0) begin
                        state_reg <= S_MASS;
                    end else if (den_reg < {16'b0, cfg.rest_density}) begin
                        den_reg     <= {16'b0, cfg.rest_density};
                        clamped_reg <= 1'b1;
                        state_reg   <= S_MASS;
                    end else begin
                        norm_reg    <= den_reg;
                        p_reg       <= 6'd63;
                        log_sel_reg <= 1'b0;
                        state_reg   <= S_NORM;
                    end
                end
                S_NORM: begin
                    // shift up one bit a cycle until the top bit is set
                    if (norm_reg[63]) begin
                        m_reg     <= {1'b0, norm_reg[63:33]};
                        frac_reg  <= '0;
                        it_reg    <= '0;
                        state_reg <= S_SQ;
                    end else begin
                        norm_reg <= {norm_reg[62:0], 1'b0};
                        p_reg    <= p_reg - 6'd1;
                    end
                end
                S_SQ: begin
                    mul_req_reg <= '{1'b1, SH_LOG, {32'b0, m_reg}, {32'b0, m_reg}};
                    state_reg   <= S_SQ_W;
                end
                S_SQ_W: begin
                    if (mul_rsp.done) begin
                        if (|mul_rsp.res[63:31]) begin
                            m_reg    <= mul_rsp.res[32:1];
                            frac_reg <= {frac_reg[28:0], 1'b1};
                        end else begin
                            m_reg    <= mul_rsp.res[31:0];
                            frac_reg <= {frac_reg[28:0], 1'b0};
                        end
                        it_reg    <= it_reg + 5'd1;
                        state_reg <= (it_reg == 5'(LOG_FRAC - 1)) ? S_LOG_END : S_SQ;
                    end
                end
                S_LOG_END: begin
                    if (!log_sel_reg) begin
                        logd_reg    <= lv;
                        norm_reg    <= {16'b0, cfg.rest_density};
                        p_reg       <= 6'd63;
                        log_sel_reg <= 1'b1;
                        state_reg   <= S_NORM;
                    end else begin
                        mul_req_reg <= '{1'b1, SH_EXP, {32'b0, cfg.exponent}, l_pos};
                        state_reg   <= S_Y_W;
                    end
                end
                S_Y_W: begin
                    if (mul_rsp.done) begin
                        y_reg     <= mul_rsp.res;
                        r_reg     <= 32'h4000_0000;
                        j_reg     <= '0;
                        state_reg <= S_EXP;
                    end
                end
                S_EXP: begin
                    // skip clear bits of the fraction
                    if (y_reg[j_reg]) begin
                        mul_req_reg <= '{1'b1, SH_LOG, {32'b0, r_reg},
                                         {32'b0, ROOTS[5'(LOG_FRAC) - j_reg]}};
                        state_reg   <= S_EXP_W;
                    end else if (j_reg == 5'(LOG_FRAC - 1)) begin
                        state_reg <= S_EXP_END;
                    end else begin
                        j_reg <= j_reg + 5'd1;
                    end
                end
                S_EXP_W: begin
                    if (mul_rsp.done) begin
                        r_reg <= mul_rsp.res[31:0];
                        if (j_reg == 5'(LOG_FRAC - 1)) begin
                            state_reg <= S_EXP_END;
                        end else begin
                            j_reg     <= j_reg + 5'd1;
                            state_reg <= S_EXP;
                        end
                    end
                end
                S_EXP_END: begin
                    mul_req_reg <= '{1'b1, SH_FRAC, {16'b0, cfg.stiffness}, pw_m1};
                    state_reg   <= S_PRS_W;
                end
                S_PRS_W: begin
                    if (mul_rsp.done) begin
                        prs_reg   <= res_min;
                        state_reg <= S_MASS;
                    end
                end
                S_MASS: begin
                    mul_req_reg <= '{1'b1, SH_FRAC, den_reg, {16'b0, cfg.own_volume}};
                    state_reg   <= S_MASS_W;
                end
                S_MASS_W: begin
                    if (mul_rsp.done) begin
                        mass_reg  <= res_min;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg    <= 1'b1;
                        m_density_reg  <= den_reg[FIELD_W-1:0];
                        m_pressure_reg <= prs_reg[FIELD_W-1:0];
                        m_mass_reg     <= mass_reg[FIELD_W-1:0];
                        m_clamped_reg  <= clamped_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/sph_density_pressure.sv
// Neighbor items enter a two-entry queue at one per cycle while it has room.
// The back end's work per neighbor item is bound by the shared multiplier (four
// 32x32 partial products each). A closing item adds a density and a mass product;
// unless density is raised or rest density is zero, it adds two log2 of 30 squarings
// and up to 30 exp2 products as well.
// Reset (synchronous, active low) restores register defaults and starts a new particle.
module sph_density_pressure #(
    parameter int FracBits   = sdp_pkg::FRAC_BITS_DEF,
    parameter int ValueWidth = sdp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sdp_pkg::FIELD_W-1:0] s_neighbor_volume,
    input  logic [sdp_pkg::FIELD_W-1:0] s_kernel_weight,
    input  logic                        s_has_neighbor,
    input  logic                        s_last_neighbor,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sdp_pkg::FIELD_W-1:0] m_density,
    output logic [sdp_pkg::FIELD_W-1:0] m_pressure,
    output logic [sdp_pkg::FIELD_W-1:0] m_mass,
    output logic                        m_clamped,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sdp_pkg::ADDR_W-1:0]  paddr,
    input  logic [sdp_pkg::DATA_W-1:0]  pwdata,
    output logic [sdp_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import sdp_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;
    logic       push_valid;
    item_t      push_item;
    logic       push_ready;
    logic       q_valid;
    item_t      q_item;
    logic       q_pop;
    mul_req_t   mul_req;
    mul_rsp_t   mul_rsp;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_volume     <= '0;
            cfg_reg.rest_density   <= 48'd16777216000;
            cfg_reg.kernel_at_zero <= '0;
            cfg_reg.stiffness      <= '0;
            cfg_reg.exponent       <= 32'd117440512;
        end else if (wr_en) begin
            case (reg_idx)
                REG_OWN_VOLUME:     cfg_reg.own_volume     <= pwdata[FIELD_W-1:0];
                REG_REST_DENSITY:   cfg_reg.rest_density   <= pwdata[FIELD_W-1:0];
                REG_KERNEL_AT_ZERO: cfg_reg.kernel_at_zero <= pwdata[FIELD_W-1:0];
                REG_STIFFNESS:      cfg_reg.stiffness      <= pwdata[FIELD_W-1:0];
                REG_EXPONENT:       cfg_reg.exponent       <= pwdata[EXP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_OWN_VOLUME:     prdata = {16'b0, cfg_reg.own_volume};
            REG_REST_DENSITY:   prdata = {16'b0, cfg_reg.rest_density};
            REG_KERNEL_AT_ZERO: prdata = {16'b0, cfg_reg.kernel_at_zero};
            REG_STIFFNESS:      prdata = {16'b0, cfg_reg.stiffness};
            REG_EXPONENT:       prdata = {32'b0, cfg_reg.exponent};
            default:            prdata = '0;
        endcase
    end

    sdp_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_neighbor_volume (s_neighbor_volume),
        .s_kernel_weight   (s_kernel_weight),
        .s_has_neighbor    (s_has_neighbor),
        .s_last_neighbor   (s_last_neighbor),
        .push_valid        (push_valid),
        .push_item         (push_item),
        .push_ready        (push_ready)
    );

    sdp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_item   (q_item),
        .pop        (q_pop)
    );

    sdp_mul #(
        .FracBits (FracBits)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    sdp_back #(
        .FracBits   (FracBits),
        .ValueWidth (ValueWidth)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .mul_req    (mul_req),
        .mul_rsp    (mul_rsp),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_density  (m_density),
        .m_pressure (m_pressure),
        .m_mass     (m_mass),
        .m_clamped  (m_clamped)
    );

    // a raised density never carries pressure
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_clamped) |-> (m_pressure == '0))
        else $error("clamped result with nonzero pressure");

    // the multiplier is never restarted in the cycle it delivers
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.done |-> !mul_req.start)
        else $error("multiplier start collides with done");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import sdp_pkg::*;

    localparam logic [63:0] VMAX       = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          SETTLE     = 1200;
    localparam int          HOLD_LEN   = 3000;
    localparam int          IDLE_LIMIT = 20000;

    typedef struct {
        logic [47:0] density;
        logic [47:0] pressure;
        logic [47:0] mass;
        logic        clamped;
    } particle_res_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [FIELD_W-1:0]  s_neighbor_volume = '0;
    logic [FIELD_W-1:0]  s_kernel_weight = '0;
    logic                s_has_neighbor = 1'b0;
    logic                s_last_neighbor = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [FIELD_W-1:0]  m_density;
    logic [FIELD_W-1:0]  m_pressure;
    logic [FIELD_W-1:0]  m_mass;
    logic                m_clamped;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    sph_density_pressure dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_neighbor_volume(s_neighbor_volume), .s_kernel_weight(s_kernel_weight),
        .s_has_neighbor(s_has_neighbor), .s_last_neighbor(s_last_neighbor),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_density(m_density), .m_pressure(m_pressure), .m_mass(m_mass),
        .m_clamped(m_clamped),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // model state
    logic [63:0] own_vol_q = 64'd0;
    logic [63:0] rest_q = 64'd1000 << 24;
    logic [63:0] w0_q = 64'd0;
    logic [63:0] stiff_q = 64'd0;
    logic [63:0] expo_q = 64'd7 << 24;
    logic [63:0] vol_acc = 64'd0;
    logic        new_particle = 1'b1;
    logic [63:0] roots [0:30];

    particle_res_t pending_particles[$];
    int          errors = 0;
    int          burst_left = 0;
    bit          no_gaps = 0;
    logic        hold_req = 1'b0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    initial begin
        roots[0] = 64'd2 << 30;
        for (int k = 1; k <= 30; k++) roots[k] = isqrt(roots[k-1] << 30);
    end

    function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> sh;
        if (p[127:64] != 0) return ALL_ONES;
        return p[63:0];
    endfunction

    function automatic logic signed [63:0] log2_fx(logic [63:0] v);
        int                 p;
        logic [63:0]        m;
        logic [63:0]        frac;
        logic signed [63:0] res;
        p = 63;
        frac = 0;
        while (v[p] == 1'b0) p--;
        if (p >= 30) m = v >> (p - 30);
        else m = v << (30 - p);
        for (int i = 0; i < 30; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                frac = frac | 64'd1;
            end
        end
        res = p - 24;
        return res * 64'sd1073741824 + $signed(frac);
    endfunction

    function automatic logic [63:0] exp2_fx(logic [63:0] y);
        logic [63:0] n;
        logic [63:0] r;
        int          s;
        n = y >> 30;
        r = 64'd1 << 30;
        for (int j = 0; j < 30; j++)
            if (y[j]) r = (r * roots[30-j]) >> 30;
        if (n > 64) return ALL_ONES;
        s = int'(n) - 6;
        if (s > 33) return ALL_ONES;
        if (s >= 0) return r << s;
        return r >> (-s);
    endfunction

    task automatic accumulate_neighbor(logic [47:0] nv, logic [47:0] kw, logic has, logic last);
        particle_res_t      res;
        logic [63:0]        dens;
        logic [63:0]        pw;
        logic [63:0]        pr;
        logic [63:0]        ms;
        logic signed [63:0] l;
        if (new_particle) vol_acc = qmul(own_vol_q, w0_q, 24);
        if (has) begin
            pw = qmul({16'd0, nv}, {16'd0, kw}, 24);
            vol_acc = (vol_acc > ALL_ONES - pw) ? ALL_ONES : vol_acc + pw;
        end
        new_particle = 1'b0;
        if (last) begin
            pr = 0;
            res.clamped = 1'b0;
            dens = qmul(vol_acc, rest_q, 24);
            if (dens > VMAX) dens = VMAX;
            if (rest_q != 0) begin
                if (dens < rest_q) begin
                    dens = rest_q;
                    res.clamped = 1'b1;
                end else begin
                    l = log2_fx(dens) - log2_fx(rest_q);
                    if (l < 0) l = 0;
                    pw = exp2_fx(qmul(expo_q, l, 24));
                    pw = (pw >= (64'd1 << 24)) ? pw - (64'd1 << 24) : 64'd0;
                    pr = qmul(stiff_q, pw, 24);
                    if (pr > VMAX) pr = VMAX;
                end
            end
            ms = qmul(dens, own_vol_q, 24);
            if (ms > VMAX) ms = VMAX;
            res.density = dens[47:0];
            res.pressure = pr[47:0];
            res.mass = ms[47:0];
            pending_particles.push_back(res);
            vol_acc = 0;
            new_particle = 1'b1;
        end
    endtask

    // one neighbor transfer; valid stays high afterwards unless a gap follows
    task automatic send_neighbor(logic [47:0] nv, logic [47:0] kw, logic has, logic last);
        int gap;
        if (burst_left == 0) begin
            gap = no_gaps ? 0 : (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8));
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_neighbor_volume <= nv;
        s_kernel_weight <= kw;
        s_has_neighbor <= has;
        s_last_neighbor <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        accumulate_neighbor(nv, kw, has, last);
    endtask

    // drop valid, wait for every particle result, then let the back end settle
    task automatic drain;
        s_valid <= 1'b0;
        while (pending_particles.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 3;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_OWN_VOLUME:     own_vol_q = value & VMAX;
            REG_REST_DENSITY:   rest_q = value & VMAX;
            REG_KERNEL_AT_ZERO: w0_q = value & VMAX;
            REG_STIFFNESS:      stiff_q = value & VMAX;
            REG_EXPONENT:       expo_q = value & 64'hFFFF_FFFF;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [63:0] ov, logic [63:0] rd, logic [63:0] w0,
                             logic [63:0] st, logic [63:0] ex);
        write_reg(REG_OWN_VOLUME, ov);
        write_reg(REG_REST_DENSITY, rd);
        write_reg(REG_KERNEL_AT_ZERO, w0);
        write_reg(REG_STIFFNESS, st);
        write_reg(REG_EXPONENT, ex);
    endtask

    function automatic logic [47:0] rand_q();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) return 48'($urandom_range(0, 32'h0200_0000));
        if (sel < 80) return 48'({$urandom, $urandom} & VMAX);
        if (sel < 90) return 48'd0;
        return VMAX[47:0];
    endfunction

    function automatic logic [47:0] rand_weight();
        if ($urandom_range(0, 9) < 8) return 48'($urandom_range(0, 32'h0080_0000));
        return rand_q();
    endfunction

    task automatic send_particle(int n);
        for (int i = 0; i < n; i++)
            send_neighbor(rand_q(), rand_weight(), $urandom_range(0, 7) != 0, i == n - 1);
    endtask

    task automatic test_reset_defaults;
        send_neighbor(48'h100_0000, 48'h200_0000, 1'b1, 1'b0);
        send_neighbor(48'h080_0000, 48'h040_0000, 1'b1, 1'b1);
        send_neighbor(48'h000_0000, 48'h000_0000, 1'b0, 1'b1);
        drain();
    endtask

    task automatic test_directed;
        write_all(64'h100_0000, 64'h3E8_0000_00, 64'h080_0000, 64'h10_0000_0000, 64'd7 << 24);
        // empty neighborhood
        send_neighbor(48'h0, 48'h0, 1'b0, 1'b1);
        send_neighbor(VMAX[47:0], VMAX[47:0], 1'b0, 1'b1);
        // field extremes, saturating sums
        send_neighbor(VMAX[47:0], VMAX[47:0], 1'b1, 1'b0);
        send_neighbor(VMAX[47:0], VMAX[47:0], 1'b1, 1'b1);
        send_neighbor(48'h0, VMAX[47:0], 1'b1, 1'b1);
        send_neighbor(VMAX[47:0], 48'h0, 1'b1, 1'b1);
        send_neighbor(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 1'b1, 1'b1);
        send_neighbor(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 1'b1, 1'b1);
        // below rest: clamped
        send_neighbor(48'h010_0000, 48'h010_0000, 1'b1, 1'b1);
        // just above rest, and a neighbor-less item mid particle
        send_neighbor(48'h100_0000, 48'h090_0000, 1'b1, 1'b0);
        send_neighbor(48'hFFFF_FFFF_FFFF, 48'h1, 1'b0, 1'b0);
        send_neighbor(48'h100_0000, 48'h010_0000, 1'b1, 1'b1);
        send_neighbor(48'h300_0000, 48'h200_0000, 1'b1, 1'b1);
        drain();
        // zero rest density
        write_reg(REG_REST_DENSITY, 64'd0);
        send_neighbor(48'h300_0000, 48'h200_0000, 1'b1, 1'b1);
        send_neighbor(48'h0, 48'h0, 1'b0, 1'b1);
        drain();
    endtask

    task automatic test_register_extremes;
        write_all(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        send_neighbor(48'h0, 48'h0, 1'b0, 1'b1);
        send_neighbor(VMAX[47:0], VMAX[47:0], 1'b1, 1'b1);
        drain();
        write_all(64'd0, 64'd1, 64'd0, 64'd0, 64'd0);
        send_neighbor(48'h100_0000, 48'h100_0000, 1'b1, 1'b1);
        send_neighbor(48'h0, 48'h0, 1'b0, 1'b1);
        drain();
        // upper bits ignored
        write_all(64'hFFFF_0000_0100_0000, 64'hA5A5_0000_0100_0000, 64'hFFFF_0000_0200_0000,
                  64'h1234_0000_0400_0000, 64'hFFFF_FFFF_0300_0000);
        send_neighbor(48'h200_0000, 48'h300_0000, 1'b1, 1'b1);
        send_neighbor(48'h0, 48'h0, 1'b0, 1'b1);
        drain();
    endtask

    task automatic test_random_particles;
        logic [63:0] ex;
        for (int phase = 0; phase < 8; phase++) begin
            ex = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
                                             : 64'($urandom_range(0, 32'h0A00_0000));
            write_all(rand_q(), (phase == 7) ? 64'd0 : 64'($urandom_range(1, 32'hFFFF_FFFF)),
                      rand_q(), rand_q(), ex);
            no_gaps = (phase % 3 == 2);
            for (int p = 0; p < 30; p++) send_particle($urandom_range(1, 12));
            drain();
        end
        no_gaps = 0;
    endtask

    task automatic test_output_backpressure;
        write_all(64'h100_0000, 64'h100_0000, 64'h100_0000, 64'h100_0000, 64'd3 << 24);
        @(posedge aclk);
        hold_req <= 1'b1;
        @(posedge aclk);
        hold_req <= 1'b0;
        no_gaps = 1;
        for (int p = 0; p < 10; p++) send_particle($urandom_range(1, 4));
        no_gaps = 0;
        drain();
    endtask

    // receiver: compare transfers, stall on a random mode that is redrawn periodically
    int hold_cnt = 0;
    int mode_cnt = 0;
    int rx_mode = 0;
    int stall_cnt = 0;
    always @(posedge aclk) begin
        particle_res_t e;
        if (m_valid && m_ready) begin
            if (pending_particles.size() == 0) begin
                $display("%0t unexpected result density %h", $time, m_density);
                errors++;
            end else begin
                e = pending_particles.pop_front();
                if (m_density !== e.density) begin
                    $display("%0t density expected %h got %h", $time, e.density, m_density);
                    errors++;
                end
                if (m_pressure !== e.pressure) begin
                    $display("%0t pressure expected %h got %h", $time, e.pressure, m_pressure);
                    errors++;
                end
                if (m_mass !== e.mass) begin
                    $display("%0t mass expected %h got %h", $time, e.mass, m_mass);
                    errors++;
                end
                if (m_clamped !== e.clamped) begin
                    $display("%0t clamped expected %b got %b", $time, e.clamped, m_clamped);
                    errors++;
                end
            end
        end
        if (hold_req) hold_cnt = HOLD_LEN;
        mode_cnt++;
        if (mode_cnt == 200) begin
            mode_cnt = 0;
            rx_mode = $urandom_range(0, 3);
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= (mode_cnt % 4 == 0);
                default: begin
                    if (stall_cnt > 0) begin
                        stall_cnt--;
                        m_ready <= 1'b0;
                    end else begin
                        stall_cnt = $urandom_range(0, 40);
                        m_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed();
        test_register_extremes();
        test_output_backpressure();
        test_random_particles();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
